// ===== hw/rtl/assert_macros.svh =====
// assertion helpers, empty in synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: lbl");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: lbl");

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/spse_pkg.sv =====
package spse_pkg;

	localparam int VALUE_BITS = 32;
	localparam int SUM_BITS   = 48;

	// derived widths
	localparam int HALF_W    = VALUE_BITS / 2;
	localparam int CNT_W     = $clog2(VALUE_BITS);
	localparam int IN_DATA_W = ((VALUE_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((2 * SUM_BITS + 2 * VALUE_BITS + 7) / 8) * 8;
	localparam int IN_USER_W  = 1;
	localparam int OUT_USER_W = 3;

	localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};
	localparam logic [HALF_W-1:0] FIRST_ODD_DIV = HALF_W'(3);
	localparam logic [HALF_W-1:0] DIV_STRIDE    = HALF_W'(2);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROOT,
		ST_TEST,
		ST_DCHK,
		ST_DIV,
		ST_DEND,
		ST_DONE
	} state_t;

endpackage

// ===== hw/rtl/square_prime_sum_and_extremes.sv =====
// square_prime_sum_and_extremes
//
// input stream (s_*): one beat per list value; s_tdata carries the signed value,
// s_tuser the start flag that clears sums, saturation marks and extremes first.
// output stream (m_*): one beat per input beat with both test flags, the two
// saturating running sums and the signed largest and smallest of the list.
// one shared subtractor serves both the bit-pair integer root and then trial
// division of odd values by odd divisors up to the root, each trial a bit-serial
// restoring remainder between a divisor check step and a remainder test step.
// run time grows with t, the odd divisors tried; a 31-bit prime needs t near
// 23170, while negative, even and tiny values skip trial division entirely.
// one value is in flight at a time: s_tready is high only while idle.
// the result sits in the output register until taken; a stalled receiver holds
// the finished next value in the last sequencer step, nothing is dropped.
// reset clears the sums, extremes, marks and the no-items flag; the first value
// after reset seeds largest and smallest whatever its start flag.
`include "assert_macros.svh"

module square_prime_sum_and_extremes (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [spse_pkg::IN_DATA_W-1:0]     s_tdata,   // value
	input  logic [spse_pkg::IN_USER_W-1:0]     s_tuser,   // start_new
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// square_sum, prime_sum, largest, smallest, zero pad
	output logic [spse_pkg::OUT_DATA_W-1:0]    m_tdata,
	// value_is_square, value_is_prime, sum_saturated
	output logic [spse_pkg::OUT_USER_W-1:0]    m_tuser
);
	import spse_pkg::*;

	localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(VALUE_BITS / 2 - 1);
	localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(VALUE_BITS - 1);
	localparam logic [VALUE_BITS-1:0] ROOT_BIT0 = VALUE_BITS'(1) << (VALUE_BITS - 2);
	localparam logic [VALUE_BITS-1:0] VAL_TWO   = VALUE_BITS'(2);

	state_t state_q, state_d;

	// item and working registers
	logic [VALUE_BITS-1:0] raw_q;
	logic                  start_q;
	logic [VALUE_BITS-1:0] rv_q;      // root remainder
	logic [VALUE_BITS-1:0] res_q;     // root result
	logic [VALUE_BITS-1:0] bit_q;     // root bit pair
	logic [VALUE_BITS-1:0] dvd_q;     // dividend shifter
	logic [HALF_W-1:0]     rem_q;     // partial remainder
	logic [HALF_W-1:0]     d_q;       // trial divisor
	logic [CNT_W-1:0]      cnt_q;
	logic                  is_sq_q;
	logic                  is_pr_q;

	// running state, doubles as the output register
	logic [SUM_BITS-1:0]   sq_total_q;
	logic [SUM_BITS-1:0]   pr_total_q;
	logic [VALUE_BITS-1:0] max_q;
	logic [VALUE_BITS-1:0] min_q;
	logic [1:0]            marks_q;
	logic                  has_items_q;
	logic                  out_sq_q;
	logic                  out_pr_q;
	logic                  m_tvalid_q;

	// control
	logic s_fire;
	logic out_free;
	logic load_out;
	logic root_last;
	logic div_last;
	logic neg;
	logic below_two;
	logic d_over_root;

	// shared subtractor
	logic [VALUE_BITS-1:0] sub_a;
	logic [VALUE_BITS-1:0] sub_b;
	logic [VALUE_BITS:0]   sub_diff;
	logic                  sub_ge;

	// update datapath
	logic [SUM_BITS-1:0]   base_sq, base_pr;
	logic [1:0]            base_marks;
	logic                  base_has;
	logic [SUM_BITS:0]     sq_add, pr_add;
	logic [SUM_BITS-1:0]   new_sq, new_pr;
	logic [1:0]            new_marks;
	logic [VALUE_BITS-1:0] new_max, new_min;

	assign s_fire      = s_tvalid && s_tready;
	assign out_free    = !m_tvalid_q || m_tready;
	assign root_last   = (cnt_q == ROOT_LAST);
	assign div_last    = (cnt_q == DIV_LAST);
	assign neg         = raw_q[VALUE_BITS-1];
	assign below_two   = (raw_q[VALUE_BITS-1:1] == '0);
	assign d_over_root = (d_q > res_q[HALF_W-1:0]);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (s_fire) state_d = ST_ROOT;
			ST_ROOT: if (root_last) state_d = ST_TEST;
			ST_TEST: begin
				if (neg || below_two || !raw_q[0])
					state_d = ST_DONE;
				else
					state_d = ST_DCHK;
			end
			ST_DCHK: state_d = d_over_root ? ST_DONE : ST_DIV;
			ST_DIV:  if (div_last) state_d = ST_DEND;
			ST_DEND: state_d = (rem_q == '0) ? ST_DONE : ST_DCHK;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs: handshake, output load and subtractor operands
	always_comb begin
		s_tready = 1'b0;
		load_out = 1'b0;
		sub_a    = '0;
		sub_b    = '0;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_ROOT: begin
				sub_a = rv_q;
				sub_b = res_q + bit_q;
			end
			ST_DIV: begin
				sub_a = VALUE_BITS'({rem_q, dvd_q[VALUE_BITS-1]});
				sub_b = VALUE_BITS'(d_q);
			end
			ST_DONE: load_out = out_free;
			default: ;
		endcase
	end

	assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
	assign sub_ge   = !sub_diff[VALUE_BITS];

	// result update: start flag clears before this value is counted
	always_comb begin
		base_sq    = start_q ? '0 : sq_total_q;
		base_pr    = start_q ? '0 : pr_total_q;
		base_marks = start_q ? 2'b00 : marks_q;
		base_has   = start_q ? 1'b0 : has_items_q;

		sq_add = {1'b0, base_sq} + (SUM_BITS + 1)'(raw_q);
		pr_add = {1'b0, base_pr} + (SUM_BITS + 1)'(raw_q);

		new_marks = base_marks;
		new_sq    = base_sq;
		new_pr    = base_pr;
		if (is_sq_q) begin
			if (sq_add[SUM_BITS]) begin
				new_sq       = SUM_MAX;
				new_marks[0] = 1'b1;
			end else begin
				new_sq = sq_add[SUM_BITS-1:0];
			end
		end
		if (is_pr_q) begin
			if (pr_add[SUM_BITS]) begin
				new_pr       = SUM_MAX;
				new_marks[1] = 1'b1;
			end else begin
				new_pr = pr_add[SUM_BITS-1:0];
			end
		end

		if (!base_has) begin
			new_max = raw_q;
			new_min = raw_q;
		end else begin
			new_max = ($signed(raw_q) > $signed(max_q)) ? raw_q : max_q;
			new_min = ($signed(raw_q) < $signed(min_q)) ? raw_q : min_q;
		end
	end

	// control and running state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			m_tvalid_q  <= 1'b0;
			sq_total_q  <= '0;
			pr_total_q  <= '0;
			max_q       <= '0;
			min_q       <= '0;
			marks_q     <= 2'b00;
			has_items_q <= 1'b0;
			out_sq_q    <= 1'b0;
			out_pr_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				m_tvalid_q  <= 1'b1;
				sq_total_q  <= new_sq;
				pr_total_q  <= new_pr;
				max_q       <= new_max;
				min_q       <= new_min;
				marks_q     <= new_marks;
				has_items_q <= 1'b1;
				out_sq_q    <= is_sq_q;
				out_pr_q    <= is_pr_q;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (s_fire) begin
					raw_q   <= s_tdata[VALUE_BITS-1:0];
					start_q <= s_tuser[0];
					rv_q    <= s_tdata[VALUE_BITS-1:0];
					res_q   <= '0;
					bit_q   <= ROOT_BIT0;
					cnt_q   <= '0;
				end
			end
			ST_ROOT: begin
				if (sub_ge) begin
					rv_q  <= sub_diff[VALUE_BITS-1:0];
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				cnt_q <= cnt_q + 1'b1;
			end
			ST_TEST: begin
				// zero remainder after the root means an exact square
				is_sq_q <= !neg && (rv_q == '0);
				is_pr_q <= !neg && !below_two && !raw_q[0] && (raw_q == VAL_TWO);
				d_q     <= FIRST_ODD_DIV;
			end
			ST_DCHK: begin
				if (d_over_root) begin
					is_pr_q <= 1'b1;
				end else begin
					rem_q <= '0;
					dvd_q <= raw_q;
					cnt_q <= '0;
				end
			end
			ST_DIV: begin
				rem_q <= sub_ge ? sub_diff[HALF_W-1:0] : sub_a[HALF_W-1:0];
				dvd_q <= dvd_q << 1;
				cnt_q <= cnt_q + 1'b1;
			end
			ST_DEND: begin
				if (rem_q == '0)
					is_pr_q <= 1'b0;
				else
					d_q <= d_q + DIV_STRIDE;
			end
			ST_DONE: ;
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_DATA_W'({min_q, max_q, pr_total_q, sq_total_q});
	assign m_tuser  = {(marks_q != 2'b00), out_pr_q, out_sq_q};

	// a value above one is never both a square and a prime
	`ASSERT_IMPLIES(a_sq_pr_excl, clk, arst_n, m_tvalid_q, !(out_sq_q && out_pr_q))
	// extremes stay ordered
	`ASSERT_IMPLIES(a_ext_order, clk, arst_n, m_tvalid_q && has_items_q,
		$signed(max_q) >= $signed(min_q))
	// a saturation mark means its sum is pinned at the top
	`ASSERT_IMPLIES(a_sat_pinned, clk, arst_n, marks_q != 2'b00,
		(!marks_q[0] || sq_total_q == SUM_MAX) && (!marks_q[1] || pr_total_q == SUM_MAX))
	// trial divisors are odd and at least three
	`ASSERT_IMPLIES(a_div_odd, clk, arst_n, state_q == ST_DIV,
		d_q[0] && (d_q >= FIRST_ODD_DIV))
	// results leave only after the sequencer finishes
	`ASSERT_NEXT(a_load_idle, clk, arst_n, load_out, state_q == ST_IDLE && m_tvalid_q)

endmodule
